/* rtl/core/integer_to_ascii_formatter_top_defines.svh */
// Assertion macros for the integer to ASCII formatter checker.
// No dependencies; included by the checker file.
`ifndef INTEGER_TO_ASCII_FORMATTER_TOP_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_TOP_DEFINES_SVH

// Assert a property under reset gating.
`define ITAF_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assert that a signal holds while its channel is stalled.
`define ITAF_STABLE(lbl, clk, rst, cond, sig) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> $stable(sig)) \
    else $error("payload changed while stalled");

`endif

/* rtl/core/itaf_pkg.sv */
// Shared constants, types and the digit table for the integer to ASCII formatter.
// No dependencies; used by the interfaces and every module.
package itaf_pkg;

  localparam int VALUE_BITS_DEF = 64;
  localparam int MAX_WIDTH_DEF  = 64;
  localparam int NARROW_BITS    = 32;
  localparam int CNT_W          = 7;

  localparam int OP_W    = 3;
  localparam int ARG_W   = 64;
  localparam int SIZE_W  = 2;
  localparam int WIDTH_W = 7;
  localparam int CHAR_W  = 8;

  localparam logic [OP_W-1:0] OP_SDEC    = 3'd0;
  localparam logic [OP_W-1:0] OP_UDEC    = 3'd1;
  localparam logic [OP_W-1:0] OP_OCT     = 3'd2;
  localparam logic [OP_W-1:0] OP_HEXL    = 3'd3;
  localparam logic [OP_W-1:0] OP_HEXU    = 3'd4;
  localparam logic [OP_W-1:0] OP_BIN     = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_HI = 3'd7;

  localparam logic [SIZE_W-1:0] SIZE_INT   = 2'd0;
  localparam logic [SIZE_W-1:0] SIZE_LONG  = 2'd1;
  localparam logic [SIZE_W-1:0] SIZE_LLONG = 2'd2;
  localparam logic [SIZE_W-1:0] SIZE_RSVD  = 2'd3;

  localparam logic [CHAR_W-1:0] CH_NONE  = 8'h00;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;

  localparam logic [127:0] LOWER_DIGITS = "0123456789abcdef";
  localparam logic [127:0] UPPER_DIGITS = "0123456789ABCDEF";

  localparam logic [1:0] CMD_HOLD   = 2'd0;
  localparam logic [1:0] CMD_LOAD   = 2'd1;
  localparam logic [1:0] CMD_DABBLE = 2'd2;
  localparam logic [1:0] CMD_SHIFT  = 2'd3;

  typedef struct packed {
    logic [1:0]      code;
    logic [OP_W-1:0] op;
    logic            narrow;
  } unit_cmd_t;

  typedef struct packed {
    logic [3:0]       digit;
    logic             more;
    logic             dab_last;
    logic [CNT_W-1:0] count;
  } unit_stat_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] digit, input logic upper);
    logic [6:0] pos;
    pos = {~digit, 3'b000};
    return upper ? UPPER_DIGITS[pos +: 8] : LOWER_DIGITS[pos +: 8];
  endfunction

endpackage

/* rtl/core/itaf_if.sv */
// Request, text and configuration channels of the integer to ASCII formatter.
// Depends on itaf_pkg for the payload widths.
interface itaf_req_if;
  logic                             valid;
  logic                             ready;
  logic [itaf_pkg::OP_W-1:0]        operation;
  logic [itaf_pkg::ARG_W-1:0]       arg_value;
  logic [itaf_pkg::SIZE_W-1:0]      arg_size;
  logic [itaf_pkg::WIDTH_W-1:0]     min_width;
  logic                             zero_fill;
  logic                             plus_sign;

  modport source (output valid, operation, arg_value, arg_size, min_width, zero_fill,
                  plus_sign, input ready);
  modport sink (input valid, operation, arg_value, arg_size, min_width, zero_fill,
                plus_sign, output ready);
endinterface

interface itaf_txt_if;
  logic                        valid;
  logic                        ready;
  logic [itaf_pkg::CHAR_W-1:0] out_char;
  logic                        last_char;

  modport source (output valid, out_char, last_char, input ready);
  modport sink (input valid, out_char, last_char, output ready);
endinterface

interface itaf_cfg_if;
  logic valid;
  logic ready;
  logic long_is_wide;

  modport source (output valid, long_is_wide, input ready);
  modport sink (input valid, long_is_wide, output ready);
endinterface

/* rtl/core/itaf_shift_unit.sv */
// Shared digit register: double-dabble conversion, leading-zero skip and digit shift-out.
// Depends on itaf_pkg for command and status types.
module itaf_shift_unit #(
  parameter int VALUE_BITS = itaf_pkg::VALUE_BITS_DEF
) (
  input  logic                 clk,
  input  itaf_pkg::unit_cmd_t  cmd,
  input  logic [VALUE_BITS-1:0] mag,
  output itaf_pkg::unit_stat_t stat
);

  localparam int HEX_DIGITS   = (VALUE_BITS + 3) / 4;
  localparam int BIN_W        = HEX_DIGITS * 4;
  localparam int OCT_DIGITS   = (VALUE_BITS + 2) / 3;
  localparam int OCT_W        = OCT_DIGITS * 3;
  localparam int DEC_DIGITS   = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int DEC_W        = DEC_DIGITS * 4;
  localparam int MAX_BO       = (BIN_W > OCT_W) ? BIN_W : OCT_W;
  localparam int DREG_W       = (DEC_W > MAX_BO) ? DEC_W : MAX_BO;
  localparam int NARROW_STEPS = itaf_pkg::NARROW_BITS / 4;
  localparam int STEP_W       = $clog2(HEX_DIGITS + 1);
  localparam int CNT_W        = itaf_pkg::CNT_W;

  logic [DREG_W-1:0] dreg, dreg_next;
  logic [BIN_W-1:0]  breg, breg_next;
  logic [STEP_W-1:0] steps, steps_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic [DEC_W-1:0]  bcd;
  logic [3:0]        top_digit;

  always_comb begin
    bcd = dreg[DREG_W-1 -: DEC_W];
    for (int s = 0; s < 4; s++) begin
      for (int d = 0; d < DEC_DIGITS; d++) begin
        if (bcd[4*d +: 4] >= 4'd5) begin
          bcd[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
        end
      end
      bcd = {bcd[DEC_W-2:0], breg[BIN_W-1-s]};
    end
  end

  always_comb begin
    case (cmd.op)
      itaf_pkg::OP_BIN: top_digit = {3'b000, dreg[DREG_W-1]};
      itaf_pkg::OP_OCT: top_digit = {1'b0, dreg[DREG_W-1 -: 3]};
      default:          top_digit = dreg[DREG_W-1 -: 4];
    endcase
  end

  always_comb begin
    dreg_next  = dreg;
    breg_next  = breg;
    steps_next = steps;
    cnt_next   = cnt;
    case (cmd.code)
      itaf_pkg::CMD_LOAD: begin
        case (cmd.op)
          itaf_pkg::OP_SDEC, itaf_pkg::OP_UDEC: begin
            dreg_next = '0;
            if (cmd.narrow) begin
              breg_next  = BIN_W'(mag[itaf_pkg::NARROW_BITS-1:0])
                           << (BIN_W - itaf_pkg::NARROW_BITS);
              steps_next = STEP_W'(NARROW_STEPS);
            end else begin
              breg_next  = BIN_W'(mag);
              steps_next = STEP_W'(HEX_DIGITS);
            end
            cnt_next = CNT_W'(DEC_DIGITS);
          end
          itaf_pkg::OP_OCT: begin
            dreg_next = DREG_W'(mag) << (DREG_W - OCT_W);
            cnt_next  = CNT_W'(OCT_DIGITS);
          end
          itaf_pkg::OP_BIN: begin
            dreg_next = DREG_W'(mag) << (DREG_W - VALUE_BITS);
            cnt_next  = CNT_W'(VALUE_BITS);
          end
          default: begin
            dreg_next = DREG_W'(mag) << (DREG_W - BIN_W);
            cnt_next  = CNT_W'(HEX_DIGITS);
          end
        endcase
      end
      itaf_pkg::CMD_DABBLE: begin
        dreg_next  = DREG_W'(bcd) << (DREG_W - DEC_W);
        breg_next  = breg << 4;
        steps_next = steps - STEP_W'(1);
      end
      itaf_pkg::CMD_SHIFT: begin
        case (cmd.op)
          itaf_pkg::OP_BIN: dreg_next = dreg << 1;
          itaf_pkg::OP_OCT: dreg_next = dreg << 3;
          default:          dreg_next = dreg << 4;
        endcase
        cnt_next = cnt - CNT_W'(1);
      end
      default: begin
        dreg_next = dreg;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    dreg  <= dreg_next;
    breg  <= breg_next;
    steps <= steps_next;
    cnt   <= cnt_next;
  end

  assign stat.digit    = top_digit;
  assign stat.more     = (cnt > CNT_W'(1));
  assign stat.dab_last = (steps == STEP_W'(1));
  assign stat.count    = cnt;

endmodule

/* rtl/core/itaf_seq.sv */
// Sequencer: request capture, sign handling, padding and character output register.
// Depends on itaf_pkg, itaf_req_if and itaf_txt_if; drives itaf_shift_unit.
module itaf_seq #(
  parameter int VALUE_BITS = itaf_pkg::VALUE_BITS_DEF,
  parameter int MAX_WIDTH  = itaf_pkg::MAX_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  itaf_req_if.sink              req,
  itaf_txt_if.source            txt,
  input  logic                  long_is_wide,
  output itaf_pkg::unit_cmd_t   cmd,
  output logic [VALUE_BITS-1:0] mag,
  input  itaf_pkg::unit_stat_t  stat
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LOAD   = 3'd1;
  localparam logic [2:0] ST_DABBLE = 3'd2;
  localparam logic [2:0] ST_SCAN   = 3'd3;
  localparam logic [2:0] ST_PAD    = 3'd4;
  localparam logic [2:0] ST_SIGN   = 3'd5;
  localparam logic [2:0] ST_DIGIT  = 3'd6;

  localparam int WIDTH_W = itaf_pkg::WIDTH_W;
  localparam int CHAR_W  = itaf_pkg::CHAR_W;

  logic [2:0]                state, state_next;
  logic [itaf_pkg::OP_W-1:0] op;
  logic                      narrow;
  logic [WIDTH_W-1:0]        width;
  logic                      zf;
  logic                      fs;
  logic [VALUE_BITS-1:0]     raw;
  logic [CHAR_W-1:0]         sign_ch, sign_next;
  logic [WIDTH_W-1:0]        pad_cnt, pad_next;
  logic [CHAR_W-1:0]         txt_char;
  logic                      txt_last;
  logic                      txt_valid;

  logic                      accept;
  logic                      slot_free;
  logic                      sign_bit;
  logic                      neg;
  logic [VALUE_BITS-1:0]     neg_raw;
  logic                      has_sign;
  logic [WIDTH_W-1:0]        total;
  logic [WIDTH_W-1:0]        pad_init;
  logic                      narrow_c;
  logic [WIDTH_W-1:0]        width_c;
  logic                      emit;
  logic [CHAR_W-1:0]         emit_char;
  logic                      emit_last;

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign slot_free = !txt_valid || txt.ready;

  assign narrow_c = (req.arg_size == itaf_pkg::SIZE_INT) ||
                    ((req.arg_size == itaf_pkg::SIZE_LONG) && !long_is_wide);
  assign width_c  = (req.min_width > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH) : req.min_width;

  assign sign_bit = narrow ? raw[itaf_pkg::NARROW_BITS-1] : raw[VALUE_BITS-1];
  assign neg      = (op == itaf_pkg::OP_SDEC) && sign_bit;
  assign neg_raw  = ~raw + VALUE_BITS'(1);
  assign mag      = !neg ? raw :
                    narrow ? VALUE_BITS'(neg_raw[itaf_pkg::NARROW_BITS-1:0]) : neg_raw;

  assign has_sign = (sign_ch != itaf_pkg::CH_NONE);
  assign total    = stat.count + WIDTH_W'(has_sign);
  assign pad_init = (width > total) ? width - total : '0;

  always_comb begin
    state_next = state;
    sign_next  = sign_ch;
    pad_next   = pad_cnt;
    emit       = 1'b0;
    emit_char  = itaf_pkg::CH_NONE;
    emit_last  = 1'b0;
    cmd.code   = itaf_pkg::CMD_HOLD;
    cmd.op     = op;
    cmd.narrow = narrow;
    case (state)
      ST_IDLE: begin
        if (accept && (req.operation <= itaf_pkg::OP_BIN)) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.code = itaf_pkg::CMD_LOAD;
        if (neg) begin
          sign_next = itaf_pkg::CH_MINUS;
        end else if ((op == itaf_pkg::OP_SDEC) && fs) begin
          sign_next = itaf_pkg::CH_PLUS;
        end else begin
          sign_next = itaf_pkg::CH_NONE;
        end
        if ((op == itaf_pkg::OP_SDEC) || (op == itaf_pkg::OP_UDEC)) begin
          state_next = ST_DABBLE;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_DABBLE: begin
        cmd.code = itaf_pkg::CMD_DABBLE;
        if (stat.dab_last) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if ((stat.digit == 4'd0) && stat.more) begin
          cmd.code = itaf_pkg::CMD_SHIFT;
        end else begin
          pad_next   = pad_init;
          state_next = (has_sign && zf) ? ST_SIGN : ST_PAD;
        end
      end
      ST_PAD: begin
        if (pad_cnt == '0) begin
          state_next = (has_sign && !zf) ? ST_SIGN : ST_DIGIT;
        end else if (slot_free) begin
          emit      = 1'b1;
          emit_char = zf ? itaf_pkg::CH_ZERO : itaf_pkg::CH_SPACE;
          pad_next  = pad_cnt - WIDTH_W'(1);
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          emit       = 1'b1;
          emit_char  = sign_ch;
          state_next = zf ? ST_PAD : ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_char = itaf_pkg::digit_char(stat.digit, op == itaf_pkg::OP_HEXU);
          emit_last = !stat.more;
          if (stat.more) begin
            cmd.code = itaf_pkg::CMD_SHIFT;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      txt_valid <= 1'b0;
    end else begin
      state     <= state_next;
      txt_valid <= emit || (txt_valid && !txt.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op     <= req.operation;
      narrow <= narrow_c;
      width  <= width_c;
      zf     <= req.zero_fill;
      fs     <= req.plus_sign;
      raw    <= narrow_c ? VALUE_BITS'(req.arg_value[itaf_pkg::NARROW_BITS-1:0])
                         : req.arg_value[VALUE_BITS-1:0];
    end
    sign_ch <= sign_next;
    pad_cnt <= pad_next;
    if (emit) begin
      txt_char <= emit_char;
      txt_last <= emit_last;
    end
  end

  assign txt.valid     = txt_valid;
  assign txt.out_char  = txt_char;
  assign txt.last_char = txt_last;

endmodule

/* rtl/core/integer_to_ascii_formatter_top.sv */
// Integer to ASCII formatter: takes one integer conversion request and sends its text
// leftmost character first, one character per transfer, the final one flagged by
// last_char. Octal, hex and binary digits come straight from one shared digit register;
// decimal first runs a double-dabble pass through that register, four value bits per
// cycle. Leading zero digit positions are then skipped one per cycle, and characters
// are sent one per cycle while the output is not stalled. Requests with a reserved
// operation code are taken but send no text. The request channel is ready only
// between requests; the last character may still wait in the output register while
// the next request is taken. long_is_wide resets to 1 and is written through cfg.
// Depends on itaf_pkg, itaf_if, itaf_shift_unit and itaf_seq.
module integer_to_ascii_formatter_top #(
  parameter int VALUE_BITS = itaf_pkg::VALUE_BITS_DEF,
  parameter int MAX_WIDTH  = itaf_pkg::MAX_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  itaf_req_if.sink   req,
  itaf_txt_if.source txt,
  itaf_cfg_if.sink   cfg
);

  logic                 long_is_wide;
  itaf_pkg::unit_cmd_t  cmd;
  itaf_pkg::unit_stat_t stat;
  logic [VALUE_BITS-1:0] mag;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_is_wide <= 1'b1;
    end else if (cfg.valid) begin
      long_is_wide <= cfg.long_is_wide;
    end
  end

  itaf_seq #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .txt         (txt),
    .long_is_wide(long_is_wide),
    .cmd         (cmd),
    .mag         (mag),
    .stat        (stat)
  );

  itaf_shift_unit #(
    .VALUE_BITS(VALUE_BITS)
  ) u_unit (
    .clk (clk),
    .cmd (cmd),
    .mag (mag),
    .stat(stat)
  );

endmodule

/* rtl/core/itaf_checker.sv */
// Port-level checker for the integer to ASCII formatter, bound to the top level.
// Depends on itaf_pkg and integer_to_ascii_formatter_top_defines.svh.
`include "integer_to_ascii_formatter_top_defines.svh"

module itaf_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_ready,
  input logic [itaf_pkg::OP_W-1:0]   req_operation,
  input logic                        txt_valid,
  input logic                        txt_ready,
  input logic [itaf_pkg::CHAR_W-1:0] txt_out_char,
  input logic                        txt_last_char
);

  `ITAF_STABLE(a_char_hold, clk, rst, txt_valid && !txt_ready, txt_out_char)
  `ITAF_STABLE(a_last_hold, clk, rst, txt_valid && !txt_ready, txt_last_char)
  `ITAF_ASSERT(a_busy_after_req, clk, rst, req_valid && req_ready && (req_operation <= itaf_pkg::OP_BIN) |=> !req_ready, "ready stayed high after a request was taken")
  `ITAF_ASSERT(a_idle_only_last, clk, rst, txt_valid && req_ready |-> txt_last_char, "a non-final character pending while idle")
  `ITAF_ASSERT(a_ready_after_last, clk, rst, $rose(req_ready) |-> txt_valid && txt_last_char, "ready returned without a final character")

endmodule

bind integer_to_ascii_formatter_top itaf_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .req_operation(req.operation),
  .txt_valid    (txt.valid),
  .txt_ready    (txt.ready),
  .txt_out_char (txt.out_char),
  .txt_last_char(txt.last_char)
);

/* bench/itaf_text_checker.sv */
`timescale 1ns / 1ps
// Checker for the integer to ASCII formatter: watches the request, text and config channels.
// It predicts each field's characters and compares them in order. Depends on itaf_pkg, itaf_if.
module itaf_text_checker (
  input  logic       clk,
  input  logic       rst,
  itaf_req_if        req,
  itaf_txt_if        txt,
  itaf_cfg_if        cfg,
  output int         fail_count,
  output int         open_chars
);

  localparam int CHAR_W  = itaf_pkg::CHAR_W;
  localparam int OP_W    = itaf_pkg::OP_W;
  localparam int ARG_W   = itaf_pkg::ARG_W;
  localparam int SIZE_W  = itaf_pkg::SIZE_W;
  localparam int WIDTH_W = itaf_pkg::WIDTH_W;

  localparam logic [CHAR_W-1:0] ALPHA_LO = 8'h61;
  localparam logic [CHAR_W-1:0] ALPHA_UP = 8'h41;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_char_t;

  text_char_t expected_text[$];
  text_char_t head;
  logic       wide_long;

  function automatic void queue_field(input logic [OP_W-1:0] op, input logic [ARG_W-1:0] raw,
                                      input logic [SIZE_W-1:0] size,
                                      input logic [WIDTH_W-1:0] width_in,
                                      input logic zf, input logic fs);
    logic [CHAR_W-1:0] built[$];
    logic [ARG_W-1:0]  mag;
    logic [CHAR_W-1:0] sign_ch;
    logic [3:0]        nib;
    int                width;
    int                shift;
    bit                narrow;
    if (op > itaf_pkg::OP_BIN) return;
    width = (width_in > itaf_pkg::MAX_WIDTH_DEF) ? itaf_pkg::MAX_WIDTH_DEF : int'(width_in);
    narrow = (size == itaf_pkg::SIZE_INT) || (size == itaf_pkg::SIZE_LONG && !wide_long);
    mag = narrow ? {32'h0, raw[31:0]} : raw;
    sign_ch = itaf_pkg::CH_NONE;
    if (op == itaf_pkg::OP_SDEC) begin
      if (narrow ? mag[31] : mag[63]) begin
        mag = narrow ? {32'h0, ~mag[31:0] + 32'd1} : ~mag + 64'd1;
        sign_ch = itaf_pkg::CH_MINUS;
      end else if (fs) begin
        sign_ch = itaf_pkg::CH_PLUS;
      end
    end
    shift = (op == itaf_pkg::OP_OCT) ? 3 : (op == itaf_pkg::OP_BIN) ? 1 : 4;
    do begin
      if (op <= itaf_pkg::OP_UDEC) begin
        built.push_back(itaf_pkg::CH_ZERO + CHAR_W'(mag % 64'd10));
        mag = mag / 64'd10;
      end else begin
        nib = mag[3:0] & 4'((1 << shift) - 1);
        if (nib < 4'd10) begin
          built.push_back(itaf_pkg::CH_ZERO + CHAR_W'(nib));
        end else begin
          built.push_back(((op == itaf_pkg::OP_HEXU) ? ALPHA_UP : ALPHA_LO) +
                          CHAR_W'(nib - 4'd10));
        end
        mag = mag >> shift;
      end
    end while (mag != 0);
    if (sign_ch != itaf_pkg::CH_NONE && zf) begin
      while (built.size() < width - 1) built.push_back(itaf_pkg::CH_ZERO);
      built.push_back(sign_ch);
    end else begin
      if (sign_ch != itaf_pkg::CH_NONE) built.push_back(sign_ch);
      while (built.size() < width) built.push_back(zf ? itaf_pkg::CH_ZERO : itaf_pkg::CH_SPACE);
    end
    for (int k = built.size() - 1; k >= 0; k--) begin
      expected_text.push_back('{ch: built[k], last: (k == 0)});
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      expected_text.delete();
      wide_long = 1'b1;
      fail_count = 0;
    end else begin
      if (txt.valid && txt.ready) begin
        if (expected_text.size() == 0) begin
          $display("%0t: unexpected char: expected none, actual char %h last %b",
                   $time, txt.out_char, txt.last_char);
          fail_count++;
        end else begin
          head = expected_text.pop_front();
          if (txt.out_char !== head.ch) begin
            $display("%0t: out_char mismatch: expected %h, actual %h",
                     $time, head.ch, txt.out_char);
            fail_count++;
          end
          if (txt.last_char !== head.last) begin
            $display("%0t: last_char mismatch: expected %b, actual %b",
                     $time, head.last, txt.last_char);
            fail_count++;
          end
        end
      end
      if (cfg.valid && cfg.ready) wide_long = cfg.long_is_wide;
      if (req.valid && req.ready) begin
        queue_field(req.operation, req.arg_value, req.arg_size, req.min_width,
                    req.zero_fill, req.plus_sign);
      end
    end
    open_chars <= expected_text.size();
  end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// Top of the integer to ASCII formatter bench: clock, reset, request and config stimulus.
// Depends on itaf_pkg, itaf_if, integer_to_ascii_formatter_top and itaf_text_checker.
module tb_top;

  localparam int OP_W    = itaf_pkg::OP_W;
  localparam int ARG_W   = itaf_pkg::ARG_W;
  localparam int SIZE_W  = itaf_pkg::SIZE_W;
  localparam int WIDTH_W = itaf_pkg::WIDTH_W;

  localparam int SETTLE_CYCLES = 200;
  localparam int DRAIN_LIMIT   = 100000;
  localparam int RX_HOLD       = 600;

  logic clk;
  logic rst;
  int   fail_count;
  int   open_chars;
  int   tx_idle_pct = 14;
  int   rx_idle_pct = 74;
  bit   stall_rx;

  itaf_req_if req_ch ();
  itaf_txt_if txt_ch ();
  itaf_cfg_if cfg_ch ();

  integer_to_ascii_formatter_top dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .txt (txt_ch),
    .cfg (cfg_ch)
  );

  itaf_text_checker text_chk (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .txt        (txt_ch),
    .cfg        (cfg_ch),
    .fail_count (fail_count),
    .open_chars (open_chars)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    txt_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_rx) begin
        txt_ch.ready <= 1'b0;
        repeat (RX_HOLD) @(posedge clk);
        stall_rx = 1'b0;
      end else begin
        txt_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_request(input logic [OP_W-1:0] op, input logic [ARG_W-1:0] value,
                              input logic [SIZE_W-1:0] size, input logic [WIDTH_W-1:0] width,
                              input logic zf, input logic fs);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.operation <= op;
    req_ch.arg_value <= value;
    req_ch.arg_size  <= size;
    req_ch.min_width <= width;
    req_ch.zero_fill <= zf;
    req_ch.plus_sign <= fs;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (open_chars != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_long_mode(input logic wide);
    cfg_ch.valid        <= 1'b1;
    cfg_ch.long_is_wide <= wide;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [ARG_W-1:0] random_arg();
    logic [ARG_W-1:0] v;
    case ($urandom_range(0, 5))
      0, 1: v = {$urandom, $urandom};
      2: v = ARG_W'($urandom_range(0, 999));
      3: v = -ARG_W'($urandom_range(1, 999));
      4: v = {$urandom, 1'b1, 31'($urandom)};
      default: begin
        case ($urandom_range(0, 4))
          0: v = '0;
          1: v = '1;
          2: v = 64'h8000_0000_0000_0000;
          3: v = 64'h7fff_ffff_ffff_ffff;
          default: v = 64'h0000_0000_8000_0000;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic logic [WIDTH_W-1:0] random_width();
    case ($urandom_range(0, 9))
      0: return WIDTH_W'($urandom_range(65, 127));
      1, 2: return WIDTH_W'($urandom_range(25, 64));
      default: return WIDTH_W'($urandom_range(0, 24));
    endcase
  endfunction

  task automatic run_random(input int count, input bit with_stall);
    int               sent;
    logic [OP_W-1:0] op;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(19) == 0) begin
        op = OP_W'($urandom_range(itaf_pkg::OP_RSVD_LO, itaf_pkg::OP_RSVD_HI));
      end else begin
        op = OP_W'($urandom_range(itaf_pkg::OP_SDEC, itaf_pkg::OP_BIN));
      end
      send_request(op, random_arg(),
                   SIZE_W'($urandom_range(itaf_pkg::SIZE_INT, itaf_pkg::SIZE_RSVD)),
                   random_width(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      if (op <= itaf_pkg::OP_BIN) begin
        sent++;
        if (with_stall && sent == count / 2) stall_rx = 1'b1;
      end
    end
  endtask

  initial begin
    int guard;
    rst                 <= 1'b1;
    req_ch.valid        <= 1'b0;
    req_ch.operation    <= itaf_pkg::OP_SDEC;
    req_ch.arg_value    <= '0;
    req_ch.arg_size     <= itaf_pkg::SIZE_INT;
    req_ch.min_width    <= '0;
    req_ch.zero_fill    <= 1'b0;
    req_ch.plus_sign    <= 1'b0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.long_is_wide <= 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_request(itaf_pkg::OP_SDEC, 64'd0, itaf_pkg::SIZE_INT, 7'd0, 1'b0, 1'b0);
    send_request(itaf_pkg::OP_SDEC, 64'h0000_0000_8000_0000, itaf_pkg::SIZE_INT, 7'd0,
                 1'b0, 1'b0);
    send_request(itaf_pkg::OP_SDEC, 64'h8000_0000_0000_0000, itaf_pkg::SIZE_LLONG, 7'd0,
                 1'b0, 1'b0);
    send_request(itaf_pkg::OP_SDEC, 64'h0000_0000_7fff_ffff, itaf_pkg::SIZE_INT, 7'd15,
                 1'b0, 1'b1);
    send_request(itaf_pkg::OP_SDEC, 64'h0000_0000_ffff_fffb, itaf_pkg::SIZE_INT, 7'd8,
                 1'b1, 1'b0);
    send_request(itaf_pkg::OP_SDEC, 64'd42, itaf_pkg::SIZE_INT, 7'd6, 1'b1, 1'b1);
    send_request(itaf_pkg::OP_UDEC, '1, itaf_pkg::SIZE_LLONG, 7'd0, 1'b0, 1'b1);
    send_request(itaf_pkg::OP_UDEC, '1, itaf_pkg::SIZE_INT, 7'd0, 1'b0, 1'b0);
    send_request(itaf_pkg::OP_OCT, '1, itaf_pkg::SIZE_LLONG, 7'd0, 1'b0, 1'b0);
    send_request(itaf_pkg::OP_HEXL, 64'hdead_beef_cafe_f00d, itaf_pkg::SIZE_LLONG, 7'd0,
                 1'b0, 1'b0);
    send_request(itaf_pkg::OP_HEXU, 64'hdead_beef_cafe_f00d, itaf_pkg::SIZE_LLONG, 7'd20,
                 1'b1, 1'b0);
    send_request(itaf_pkg::OP_BIN, '1, itaf_pkg::SIZE_LLONG, 7'd0, 1'b0, 1'b0);
    send_request(itaf_pkg::OP_BIN, 64'd0, itaf_pkg::SIZE_LLONG, 7'd64, 1'b1, 1'b1);
    send_request(itaf_pkg::OP_OCT, 64'd8, itaf_pkg::SIZE_INT, 7'd10, 1'b0, 1'b1);
    send_request(itaf_pkg::OP_RSVD_LO, '1, itaf_pkg::SIZE_INT, 7'd5, 1'b0, 1'b0);
    send_request(itaf_pkg::OP_RSVD_HI, '1, itaf_pkg::SIZE_LLONG, 7'd5, 1'b1, 1'b1);
    send_request(itaf_pkg::OP_SDEC, '1, itaf_pkg::SIZE_RSVD, 7'd0, 1'b0, 1'b0);
    send_request(itaf_pkg::OP_UDEC, 64'd7, itaf_pkg::SIZE_INT, 7'd127, 1'b0, 1'b0);
    send_request(itaf_pkg::OP_SDEC, '1, itaf_pkg::SIZE_INT, 7'd64, 1'b1, 1'b0);
    send_request(itaf_pkg::OP_SDEC, 64'h0000_0001_8000_0000, itaf_pkg::SIZE_LONG, 7'd0,
                 1'b0, 1'b0);
    send_request(itaf_pkg::OP_HEXL, 64'd0, itaf_pkg::SIZE_INT, 7'd1, 1'b0, 1'b0);
    send_request(itaf_pkg::OP_SDEC, -64'd7, itaf_pkg::SIZE_LLONG, 7'd1, 1'b1, 1'b0);
    send_request(itaf_pkg::OP_BIN, 64'd5, itaf_pkg::SIZE_LONG, 7'd100, 1'b0, 1'b1);

    wait_idle();
    write_long_mode(1'b0);
    run_random(150, 1'b1);

    wait_idle();
    tx_idle_pct = 74;
    rx_idle_pct = 14;
    write_long_mode(1'b1);
    run_random(150, 1'b0);

    wait_idle();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_long_mode(1'b0);
    run_random(75, 1'b0);

    wait_idle();
    write_long_mode(1'b1);
    run_random(75, 1'b0);

    req_ch.valid <= 1'b0;
    guard = 0;
    do begin
      @(posedge clk);
      guard++;
    end while (open_chars != 0 && guard < DRAIN_LIMIT);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && open_chars == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/itaf_pkg.sv
rtl/core/itaf_if.sv
rtl/core/itaf_shift_unit.sv
rtl/core/itaf_seq.sv
rtl/core/integer_to_ascii_formatter_top.sv
rtl/core/itaf_checker.sv
bench/itaf_text_checker.sv
bench/tb_top.sv
